### rtl/float_to_minifloat_packer_assert.svh
`ifndef FLOAT_TO_MINIFLOAT_PACKER_ASSERT_SVH
`define FLOAT_TO_MINIFLOAT_PACKER_ASSERT_SVH

// Property that must hold at every rising edge outside reset.
`define F2MP_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define F2MP_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

### rtl/f2mp_pkg.sv
`default_nettype none

package f2mp_pkg;

    localparam int MAX_EXPONENT_WIDTH_DEF = 8;
    localparam int MAX_MANTISSA_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF        = 4;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int SID_W       = 2;
    localparam int NUM_STREAMS = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int EW_CFG_W   = 4;
    localparam int OFF_W      = 9;
    localparam int MW_CFG_W   = 5;

    localparam int SGL_FRAC_W  = 23;
    localparam int SGL_EXP_W   = 8;
    localparam int SGL_BIAS    = 127;
    localparam int DBL_FRAC_W  = 52;
    localparam int DBL_EXP_W   = 11;
    localparam int DBL_BIAS    = 1023;
    localparam int EXP_CALC_W  = 13;

    typedef enum logic [SID_W-1:0] {
        SID_SIGN = 2'd0,
        SID_EXP  = 2'd1,
        SID_MANT = 2'd2
    } t_stream_id;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOUBLE_MODE     = 2'd0,
        CFG_EXPONENT_WIDTH  = 2'd1,
        CFG_EXPONENT_OFFSET = 2'd2,
        CFG_MANTISSA_WIDTH  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                       double_mode;
        logic [EW_CFG_W-1:0]        exponent_width;
        logic signed [OFF_W-1:0]    exponent_offset;
        logic [MW_CFG_W-1:0]        mantissa_width;
    } t_cfg;

    localparam logic                    RST_DOUBLE_MODE     = 1'b0;
    localparam logic [EW_CFG_W-1:0]     RST_EXPONENT_WIDTH  = 4'd4;
    localparam logic signed [OFF_W-1:0] RST_EXPONENT_OFFSET = 9'sd7;
    localparam logic [MW_CFG_W-1:0]     RST_MANTISSA_WIDTH  = 5'd16;

endpackage

`default_nettype wire

### rtl/f2mp_if.sv
`default_nettype none

interface f2mp_in_if;
    logic                           valid;
    logic                           ready;
    logic [f2mp_pkg::VALUE_W-1:0]   value_bits;
    logic                           final_element;

    modport source (output valid, output value_bits, output final_element, input ready);
    modport sink (input valid, input value_bits, input final_element, output ready);
endinterface

interface f2mp_out_if;
    logic                           valid;
    logic                           ready;
    logic [f2mp_pkg::SID_W-1:0]     stream_id;
    logic [f2mp_pkg::BYTE_W-1:0]    byte_value;
    logic                           run_end;

    modport source (output valid, output stream_id, output byte_value, output run_end,
                    input ready);
    modport sink (input valid, input stream_id, input byte_value, input run_end,
                  output ready);
endinterface

`default_nettype wire

### rtl/f2mp_front.sv
`default_nettype none

module f2mp_front #(
    parameter int MAX_EXPONENT_WIDTH = f2mp_pkg::MAX_EXPONENT_WIDTH_DEF,
    parameter int MAX_MANTISSA_WIDTH = f2mp_pkg::MAX_MANTISSA_WIDTH_DEF,
    localparam int EW_W    = $clog2(MAX_EXPONENT_WIDTH + 1),
    localparam int MW_W    = $clog2(MAX_MANTISSA_WIDTH + 1),
    localparam int ENTRY_W = 2 + MW_W + MAX_MANTISSA_WIDTH + EW_W + MAX_EXPONENT_WIDTH
) (
    input  f2mp_pkg::t_cfg        i_cfg,
    f2mp_in_if.sink               i_in,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [ENTRY_W-1:0]    o_push_data
);

    localparam int EWC  = f2mp_pkg::EW_CFG_W;
    localparam int MWC  = f2mp_pkg::MW_CFG_W;
    localparam int XW   = f2mp_pkg::DBL_EXP_W;
    localparam int CW   = f2mp_pkg::EXP_CALC_W;
    localparam int SFW  = f2mp_pkg::SGL_FRAC_W;
    localparam int SEW  = f2mp_pkg::SGL_EXP_W;
    localparam int DFW  = f2mp_pkg::DBL_FRAC_W;

    logic                           dbl;
    logic                           sign_bit;
    logic [EWC-1:0]                 ew_c;
    logic [MWC-1:0]                 mw_c;
    logic [XW-1:0]                  ieee_exp;
    logic [XW-1:0]                  bias;
    logic signed [CW-1:0]           e_calc;
    logic [MAX_EXPONENT_WIDTH-1:0]  emax;
    logic [MAX_EXPONENT_WIDTH-1:0]  exp_val;
    logic [SFW-1:0]                 frac_top;
    logic [SFW-1:0]                 mant_sh;

    assign dbl = i_cfg.double_mode;

    assign ew_c = (i_cfg.exponent_width == '0) ? EWC'(1) :
                  (i_cfg.exponent_width > EWC'(MAX_EXPONENT_WIDTH)) ? EWC'(MAX_EXPONENT_WIDTH) :
                  i_cfg.exponent_width;
    assign mw_c = (i_cfg.mantissa_width == '0) ? MWC'(1) :
                  (i_cfg.mantissa_width > MWC'(MAX_MANTISSA_WIDTH)) ? MWC'(MAX_MANTISSA_WIDTH) :
                  i_cfg.mantissa_width;

    assign sign_bit = dbl ? i_in.value_bits[DFW + XW] : i_in.value_bits[SFW + SEW];
    assign ieee_exp = dbl ? i_in.value_bits[DFW +: XW]
                          : {{(XW - SEW){1'b0}}, i_in.value_bits[SFW +: SEW]};
    assign bias     = dbl ? XW'(f2mp_pkg::DBL_BIAS) : XW'(f2mp_pkg::SGL_BIAS);

    assign e_calc = $signed({{(CW - XW){1'b0}}, ieee_exp})
                  - $signed({{(CW - XW){1'b0}}, bias})
                  + $signed({{(CW - f2mp_pkg::OFF_W){i_cfg.exponent_offset[f2mp_pkg::OFF_W-1]}},
                             i_cfg.exponent_offset});

    assign emax = {MAX_EXPONENT_WIDTH{1'b1}} >> (EWC'(MAX_EXPONENT_WIDTH) - ew_c);

    always_comb begin
        priority if (e_calc < 0) begin
            exp_val = '0;
        end else if (e_calc > $signed({{(CW - MAX_EXPONENT_WIDTH){1'b0}}, emax})) begin
            exp_val = emax;
        end else begin
            exp_val = e_calc[MAX_EXPONENT_WIDTH-1:0];
        end
    end

    assign frac_top = dbl ? i_in.value_bits[DFW-1 -: SFW] : i_in.value_bits[SFW-1:0];
    assign mant_sh  = frac_top >> (MWC'(SFW) - mw_c);

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;
    assign o_push_data  = {i_in.final_element, mw_c[MW_W-1:0],
                           mant_sh[MAX_MANTISSA_WIDTH-1:0], ew_c[EW_W-1:0], exp_val, sign_bit};

endmodule

`default_nettype wire

### rtl/f2mp_queue.sv
`default_nettype none
`include "float_to_minifloat_packer_assert.svh"

module f2mp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = f2mp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [WIDTH-1:0]  i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [WIDTH-1:0]  o_pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [AW:0]      n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (AW + 1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr    = push ? r_wr + 1'b1 : r_wr;
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (AW + 1)'(push) - (AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    `F2MP_NEVER(a_queue_overflow, r_count > (AW + 1)'(DEPTH), "queue holds more than its depth")
    `F2MP_CHECK(a_queue_fill, (push && !pop) |=> (r_count == $past(r_count) + 1'b1), "queue fill lost a request")

endmodule

`default_nettype wire

### rtl/f2mp_back.sv
`default_nettype none
`include "float_to_minifloat_packer_assert.svh"

module f2mp_back #(
    parameter int MAX_EXPONENT_WIDTH = f2mp_pkg::MAX_EXPONENT_WIDTH_DEF,
    parameter int MAX_MANTISSA_WIDTH = f2mp_pkg::MAX_MANTISSA_WIDTH_DEF,
    localparam int EW_W    = $clog2(MAX_EXPONENT_WIDTH + 1),
    localparam int MW_W    = $clog2(MAX_MANTISSA_WIDTH + 1),
    localparam int ENTRY_W = 2 + MW_W + MAX_MANTISSA_WIDTH + EW_W + MAX_EXPONENT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  logic [ENTRY_W-1:0]    i_pop_data,
    f2mp_out_if.source            o_out
);

    localparam int BW    = f2mp_pkg::BYTE_W;
    localparam int NS    = f2mp_pkg::NUM_STREAMS;
    localparam int MAXW  = (MAX_MANTISSA_WIDTH > MAX_EXPONENT_WIDTH) ?
                           MAX_MANTISSA_WIDTH : MAX_EXPONENT_WIDTH;
    localparam int ACC_W = BW - 1 + MAXW;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int SW    = f2mp_pkg::SID_W;

    logic                           e_final;
    logic [MW_W-1:0]                e_mw;
    logic [MAX_MANTISSA_WIDTH-1:0]  e_mant;
    logic [EW_W-1:0]                e_ew;
    logic [MAX_EXPONENT_WIDTH-1:0]  e_exp;
    logic                           e_sign;

    logic [ACC_W-1:0]               r_acc [NS];
    logic [CNT_W-1:0]               r_cnt [NS];
    logic                           r_final;
    logic                           r_out_valid;
    f2mp_pkg::t_stream_id           r_out_sid;
    logic [BW-1:0]                  r_out_byte;
    logic                           r_out_end;

    logic [ACC_W-1:0]               n_acc [NS];
    logic [CNT_W-1:0]               n_cnt [NS];
    logic                           n_final;

    logic [ACC_W-1:0]               a_acc [NS];
    logic [CNT_W-1:0]               a_cnt [NS];
    logic [ACC_W-1:0]               new_val [NS];
    logic [CNT_W-1:0]               new_n [NS];
    logic [NS-1:0]                  emit_ok;
    logic [NS-1:0]                  a_ok;
    f2mp_pkg::t_stream_id           sel;
    logic [SW-1:0]                  sel_idx;
    logic                           out_free;
    logic                           do_emit;
    logic                           more;
    logic                           idle_after;
    logic                           load;

    assign {e_final, e_mw, e_mant, e_ew, e_exp, e_sign} = i_pop_data;

    assign new_val[0] = ACC_W'(e_sign);
    assign new_val[1] = ACC_W'(e_exp);
    assign new_val[2] = ACC_W'(e_mant);
    assign new_n[0]   = CNT_W'(1);
    assign new_n[1]   = CNT_W'(e_ew);
    assign new_n[2]   = CNT_W'(e_mw);

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            emit_ok[s] = (r_cnt[s] >= CNT_W'(BW)) || (r_final && (r_cnt[s] != '0));
        end
    end

    always_comb begin
        priority if (emit_ok[0]) begin
            sel = f2mp_pkg::SID_SIGN;
        end else if (emit_ok[1]) begin
            sel = f2mp_pkg::SID_EXP;
        end else begin
            sel = f2mp_pkg::SID_MANT;
        end
    end

    assign sel_idx  = sel;
    assign out_free = !r_out_valid || o_out.ready;
    assign do_emit  = (|emit_ok) && out_free;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            a_acc[s] = r_acc[s];
            a_cnt[s] = r_cnt[s];
            if (do_emit && (sel_idx == SW'(s))) begin
                if (r_cnt[s] >= CNT_W'(BW)) begin
                    a_acc[s] = r_acc[s] >> BW;
                    a_cnt[s] = r_cnt[s] - CNT_W'(BW);
                end else begin
                    a_acc[s] = '0;
                    a_cnt[s] = '0;
                end
            end
            a_ok[s] = (a_cnt[s] >= CNT_W'(BW)) || (r_final && (a_cnt[s] != '0));
        end
    end

    assign more        = |a_ok;
    assign idle_after  = do_emit ? !more : !(|emit_ok);
    assign load        = i_pop_valid && idle_after;
    assign o_pop_ready = idle_after;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_acc[s] = load ? (a_acc[s] | (new_val[s] << a_cnt[s])) : a_acc[s];
            n_cnt[s] = load ? (a_cnt[s] + new_n[s]) : a_cnt[s];
        end
        n_final = load ? e_final : r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_acc[s] <= '0;
                r_cnt[s] <= '0;
            end
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                r_acc[s] <= n_acc[s];
                r_cnt[s] <= n_cnt[s];
            end
            r_final <= n_final;
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_sid  <= sel;
            r_out_byte <= r_acc[sel_idx][BW-1:0];
            r_out_end  <= !more;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.stream_id  = r_out_sid;
    assign o_out.byte_value = r_out_byte;
    assign o_out.run_end    = r_out_end;

    `F2MP_CHECK(a_final_drained, (r_final && !(|emit_ok)) |-> (r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0), "flushed streams still hold bits")
    `F2MP_CHECK(a_run_pending, (r_out_valid && !r_out_end) |-> (|emit_ok), "request ended without its last byte")

endmodule

`default_nettype wire

### rtl/float_to_minifloat_packer.sv
// An accepted request passes through the queue and the stream accumulators to the output
// register. Throughput: the output register moves one byte per cycle while the output is
// ready, and the packing stage takes the next item as it emits the last byte of the current
// one. A four-entry queue behind the classifying front end keeps input requests flowing
// while the output stalls. Reset is synchronous and active low: it empties the queue,
// clears the pending bits of all three streams and restores the configuration defaults.
`default_nettype none

module float_to_minifloat_packer #(
    parameter int MAX_EXPONENT_WIDTH = f2mp_pkg::MAX_EXPONENT_WIDTH_DEF,
    parameter int MAX_MANTISSA_WIDTH = f2mp_pkg::MAX_MANTISSA_WIDTH_DEF,
    parameter int QUEUE_DEPTH        = f2mp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [f2mp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [f2mp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    f2mp_in_if.sink                            i_in,
    f2mp_out_if.source                         o_out
);

    localparam int EW_W    = $clog2(MAX_EXPONENT_WIDTH + 1);
    localparam int MW_W    = $clog2(MAX_MANTISSA_WIDTH + 1);
    localparam int ENTRY_W = 2 + MW_W + MAX_MANTISSA_WIDTH + EW_W + MAX_EXPONENT_WIDTH;

    f2mp_pkg::t_cfg       r_cfg;
    f2mp_pkg::t_cfg       n_cfg;
    logic                 push_valid;
    logic                 push_ready;
    logic [ENTRY_W-1:0]   push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [ENTRY_W-1:0]   pop_data;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (f2mp_pkg::t_cfg_idx'(i_cfg_idx))
                f2mp_pkg::CFG_DOUBLE_MODE: begin
                    n_cfg.double_mode = i_cfg_data[0];
                end
                f2mp_pkg::CFG_EXPONENT_WIDTH: begin
                    n_cfg.exponent_width = i_cfg_data[f2mp_pkg::EW_CFG_W-1:0];
                end
                f2mp_pkg::CFG_EXPONENT_OFFSET: begin
                    n_cfg.exponent_offset = $signed(i_cfg_data[f2mp_pkg::OFF_W-1:0]);
                end
                f2mp_pkg::CFG_MANTISSA_WIDTH: begin
                    n_cfg.mantissa_width = i_cfg_data[f2mp_pkg::MW_CFG_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_mode     <= f2mp_pkg::RST_DOUBLE_MODE;
            r_cfg.exponent_width  <= f2mp_pkg::RST_EXPONENT_WIDTH;
            r_cfg.exponent_offset <= f2mp_pkg::RST_EXPONENT_OFFSET;
            r_cfg.mantissa_width  <= f2mp_pkg::RST_MANTISSA_WIDTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    f2mp_front #(
        .MAX_EXPONENT_WIDTH (MAX_EXPONENT_WIDTH),
        .MAX_MANTISSA_WIDTH (MAX_MANTISSA_WIDTH)
    ) u_front (
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    f2mp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    f2mp_back #(
        .MAX_EXPONENT_WIDTH (MAX_EXPONENT_WIDTH),
        .MAX_MANTISSA_WIDTH (MAX_MANTISSA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import f2mp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 9;
    localparam int DIRECTED_ROWS = 34;

    typedef struct packed {
        t_stream_id  sid;
        logic [7:0]  value;
        logic        last;
    } t_out_byte;

    typedef struct packed {
        logic             is_cfg;
        t_cfg_idx         reg_idx;
        logic [8:0]       reg_data;
        logic [63:0]      value;
        logic             fin;
        logic [2:0]       n_known;
        logic [3:0][9:0]  known;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    f2mp_in_if  in_if ();
    f2mp_out_if out_if ();

    float_to_minifloat_packer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    logic cfg_double;
    int   cfg_ew;
    int   cfg_off;
    int   cfg_mw;
    logic [7:0] stream_bits [NUM_STREAMS];
    int         stream_fill [NUM_STREAMS];

    t_out_byte bytes_fresh[$];
    t_out_byte bytes_awaited[$];
    t_out_byte head;
    t_stim_row directed [DIRECTED_ROWS];

    int error_count = 0;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 50)
            $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    function automatic int eff_ew();
        if (cfg_ew < 1) return 1;
        if (cfg_ew > MAX_EXPONENT_WIDTH_DEF) return MAX_EXPONENT_WIDTH_DEF;
        return cfg_ew;
    endfunction

    function automatic int eff_mw();
        if (cfg_mw < 1) return 1;
        if (cfg_mw > MAX_MANTISSA_WIDTH_DEF) return MAX_MANTISSA_WIDTH_DEF;
        return cfg_mw;
    endfunction

    function automatic void append_bits(input t_stream_id sid, input logic [15:0] v,
                                        input int nbits, input logic fin);
        for (int b = 0; b < nbits; b++) begin
            stream_bits[sid][stream_fill[sid]] = v[b];
            stream_fill[sid]++;
            if (stream_fill[sid] == 8) begin
                bytes_fresh.push_back('{sid: sid, value: stream_bits[sid], last: 1'b0});
                stream_bits[sid] = '0;
                stream_fill[sid] = 0;
            end
        end
        if (fin && stream_fill[sid] != 0) begin
            bytes_fresh.push_back('{sid: sid, value: stream_bits[sid], last: 1'b0});
            stream_bits[sid] = '0;
            stream_fill[sid] = 0;
        end
    endfunction

    function automatic void pack_item(input logic [63:0] v, input logic fin);
        int ew;
        int mw;
        int e;
        int emax;
        logic sgn;
        logic [51:0] frac;
        logic [15:0] mant;
        ew = eff_ew();
        mw = eff_mw();
        if (cfg_double) begin
            sgn  = v[63];
            e    = int'(v[62:52]) - DBL_BIAS + cfg_off;
            frac = v[51:0];
            mant = 16'(frac >> (DBL_FRAC_W - mw));
        end else begin
            sgn  = v[31];
            e    = int'(v[30:23]) - SGL_BIAS + cfg_off;
            frac = {29'b0, v[22:0]};
            mant = 16'(frac >> (SGL_FRAC_W - mw));
        end
        mant = mant & 16'((32'd1 << mw) - 32'd1);
        emax = (1 << ew) - 1;
        if (e < 0) e = 0;
        if (e > emax) e = emax;
        bytes_fresh.delete();
        append_bits(SID_SIGN, {15'b0, sgn}, 1, fin);
        append_bits(SID_EXP, 16'(e), ew, fin);
        append_bits(SID_MANT, mant, mw, fin);
        if (bytes_fresh.size() > 0) bytes_fresh[bytes_fresh.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int target;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0) begin
            target = (cfg_double ? DBL_BIAS : SGL_BIAS) - cfg_off
                     + int'($urandom_range(0, (1 << eff_ew()) + 1)) - 1;
            if (target < 0) target = 0;
            if (cfg_double) begin
                if (target > 2047) target = 2047;
                v[62:52] = target[10:0];
            end else begin
                if (target > 255) target = 255;
                v[30:23] = target[7:0];
            end
        end
        return v;
    endfunction

    function automatic t_stim_row stim_item(input logic [63:0] v, input logic fin);
        t_stim_row r;
        r = '0;
        r.value = v;
        r.fin = fin;
        return r;
    endfunction

    function automatic t_stim_row stim_known(input logic [63:0] v, input logic fin,
                                             input int n, input logic [9:0] r0,
                                             input logic [9:0] r1, input logic [9:0] r2,
                                             input logic [9:0] r3);
        t_stim_row r;
        r = stim_item(v, fin);
        r.n_known = 3'(n);
        r.known[0] = r0;
        r.known[1] = r1;
        r.known[2] = r2;
        r.known[3] = r3;
        return r;
    endfunction

    function automatic t_stim_row stim_cfg(input t_cfg_idx idx, input logic [8:0] data);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_value(input logic [63:0] v, input logic fin, input int gap,
                              input int n_known, input logic [3:0][9:0] known);
        in_if.valid         <= 1'b1;
        in_if.value_bits    <= v;
        in_if.final_element <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pack_item(v, fin);
        if (n_known != 0) begin
            bytes_fresh.delete();
            for (int i = 0; i < n_known; i++)
                bytes_fresh.push_back('{sid: t_stream_id'(known[i][9:8]),
                                       value: known[i][7:0], last: (i == n_known - 1)});
        end
        foreach (bytes_fresh[i]) bytes_awaited.push_back(bytes_fresh[i]);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drops the request line, waits for every expected byte and lets the queue settle.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (bytes_awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [8:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_DOUBLE_MODE:     cfg_double = data[0];
            CFG_EXPONENT_WIDTH:  cfg_ew = int'(data[3:0]);
            CFG_EXPONENT_OFFSET: cfg_off = int'($signed(data));
            CFG_MANTISSA_WIDTH:  cfg_mw = int'(data[4:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [8:0] off;
        logic [3:0] ew;
        logic [4:0] mw;
        logic       dm;
        case (phase)
            0: begin
                dm = 1'b0; ew = 4'd0; off = 9'h101; mw = 5'd0;
            end
            1: begin
                dm = 1'b1; ew = 4'd15; off = 9'h0FF; mw = 5'd31;
            end
            default: begin
                dm = 1'($urandom);
                ew = 4'($urandom);
                mw = 5'($urandom);
                case ($urandom_range(0, 5))
                    0: off = 9'h101;
                    1: off = 9'h0FF;
                    2: off = 9'h000;
                    default: off = 9'($urandom);
                endcase
            end
        endcase
        write_reg(CFG_DOUBLE_MODE, {8'($urandom), dm});
        write_reg(CFG_EXPONENT_WIDTH, {5'($urandom), ew});
        write_reg(CFG_EXPONENT_OFFSET, off);
        write_reg(CFG_MANTISSA_WIDTH, {4'($urandom), mw});
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (bytes_awaited.size() == 0) begin
                flag_error($sformatf("unexpected byte: stream %0d value %02h end %0b",
                                     out_if.stream_id, out_if.byte_value, out_if.run_end));
            end else begin
                head = bytes_awaited.pop_front();
                if (out_if.stream_id !== head.sid)
                    flag_error($sformatf("stream id %0d, expected %0d",
                                         out_if.stream_id, head.sid));
                if (out_if.byte_value !== head.value)
                    flag_error($sformatf("stream %0d byte %02h, expected %02h",
                                         head.sid, out_if.byte_value, head.value));
                if (out_if.run_end !== head.last)
                    flag_error($sformatf("stream %0d run end %0b, expected %0b",
                                         head.sid, out_if.run_end, head.last));
            end
        end
    end

    initial begin
        int unsigned tick;
        int unsigned style;
        tick = 0;
        style = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (tick % 48 == 0) style = $urandom_range(0, 3);
            case (style)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom);
                2: out_if.ready <= ($urandom_range(0, 7) != 0);
                default: out_if.ready <= ((tick % 16) >= 10);
            endcase
            tick++;
        end
    end

    initial begin
        int gap;
        int burst_left;
        logic steady;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_DOUBLE_MODE;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.value_bits    = '0;
        in_if.final_element = 1'b0;
        cfg_double = RST_DOUBLE_MODE;
        cfg_ew     = int'(RST_EXPONENT_WIDTH);
        cfg_off    = int'(RST_EXPONENT_OFFSET);
        cfg_mw     = int'(RST_MANTISSA_WIDTH);
        for (int s = 0; s < NUM_STREAMS; s++) begin
            stream_bits[s] = '0;
            stream_fill[s] = 0;
        end

        directed = '{
            stim_known(64'h0, 1'b1, 4, {SID_SIGN, 8'h00}, {SID_EXP, 8'h00},
                       {SID_MANT, 8'h00}, {SID_MANT, 8'h00}),
            stim_known(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4, {SID_SIGN, 8'h01},
                       {SID_EXP, 8'h0F}, {SID_MANT, 8'hFF}, {SID_MANT, 8'hFF}),
            stim_known(64'h3F80_0000, 1'b1, 4, {SID_SIGN, 8'h00}, {SID_EXP, 8'h07},
                       {SID_MANT, 8'h00}, {SID_MANT, 8'h00}),
            stim_item(64'hC049_0FDB, 1'b0),
            stim_item(64'h0000_0001, 1'b0),
            stim_item(64'h7F7F_FFFF, 1'b0),
            stim_item(64'h7FC0_0000, 1'b1),
            stim_cfg(CFG_EXPONENT_WIDTH, 9'd8),
            stim_cfg(CFG_MANTISSA_WIDTH, 9'd8),
            stim_cfg(CFG_EXPONENT_OFFSET, 9'd127),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'hBF80_0000, 1'b0, 2, {SID_EXP, 8'h7F}, {SID_MANT, 8'h00}, '0, '0),
            stim_known(64'h3F80_0000, 1'b1, 3, {SID_SIGN, 8'h7F}, {SID_EXP, 8'h7F},
                       {SID_MANT, 8'h00}, '0),
            stim_cfg(CFG_DOUBLE_MODE, 9'd1),
            stim_cfg(CFG_EXPONENT_OFFSET, 9'h101),
            stim_cfg(CFG_EXPONENT_WIDTH, 9'd1),
            stim_cfg(CFG_MANTISSA_WIDTH, 9'd1),
            stim_known(64'h3FF0_0000_0000_0000, 1'b1, 3, {SID_SIGN, 8'h00},
                       {SID_EXP, 8'h00}, {SID_MANT, 8'h00}, '0),
            stim_known(64'hFFF0_0000_0000_0000, 1'b1, 3, {SID_SIGN, 8'h01},
                       {SID_EXP, 8'h01}, {SID_MANT, 8'h00}, '0),
            stim_cfg(CFG_EXPONENT_OFFSET, 9'h0FF),
            stim_cfg(CFG_EXPONENT_WIDTH, 9'd0),
            stim_cfg(CFG_MANTISSA_WIDTH, 9'd0),
            stim_item(64'h8000_0000_0000_0000, 1'b0),
            stim_item(64'h7FEF_FFFF_FFFF_FFFF, 1'b1),
            stim_cfg(CFG_EXPONENT_WIDTH, 9'd15),
            stim_cfg(CFG_MANTISSA_WIDTH, 9'd31),
            stim_item(64'h0010_0000_0000_0000, 1'b0),
            stim_item(64'h4009_21FB_5444_2D18, 1'b1),
            stim_cfg(CFG_DOUBLE_MODE, 9'h1FE)
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            if (directed[r].is_cfg) begin
                wait_idle();
                write_reg(directed[r].reg_idx, directed[r].reg_data);
            end else begin
                send_value(directed[r].value, directed[r].fin, $urandom_range(0, 2),
                           directed[r].n_known, directed[r].known);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            configure_phase(phase);
            steady = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 8);
            repeat (PHASE_ITEMS) begin
                if (steady) begin
                    gap = 0;
                end else if (burst_left > 1) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    burst_left = $urandom_range(1, 8);
                    gap = $urandom_range(1, 6);
                end
                send_value(random_value(), ($urandom_range(0, 7) == 0), gap, 0, '0);
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
